[sv/onewire_slave_controller_assert.svh]
// assertion macros, clocked on clk and disabled while arst_n is low
`ifndef ONEWIRE_SLAVE_CONTROLLER_ASSERT_SVH
`define ONEWIRE_SLAVE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define OWS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("onewire slave assertion failed");

// next-cycle implication
`define OWS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("onewire slave assertion failed");

`endif

[sv/ows_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ows_pkg;

	localparam int SCRATCH_BYTES = 16;
	localparam int SCRATCH_AW = $clog2(SCRATCH_BYTES);
	localparam int SEND_BYTES = 8;
	localparam int WRITE_BYTES = 3;
	localparam int WRITE_START = 2 % SCRATCH_BYTES;
	localparam int ROM_BITS = 64;

	localparam int IN_TDATA_W = 16;
	localparam int IN_TUSER_W = 2;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 64;

	localparam logic [7:0] ROM_READ = 8'h33;
	localparam logic [7:0] ROM_MATCH = 8'h55;
	localparam logic [7:0] ROM_SKIP = 8'hCC;
	localparam logic [7:0] ROM_SEARCH = 8'hF0;
	localparam logic [7:0] ROM_ALARM = 8'hEC;

	// rom participation: bit 0 send, bit 1 complement, bit 2 compare
	localparam logic [2:0] MODE_NONE = 3'b000;
	localparam logic [2:0] MODE_READ = 3'b001;
	localparam logic [2:0] MODE_MATCH = 3'b100;
	localparam logic [2:0] MODE_SEARCH = 3'b111;
	localparam logic [1:0] SUB_NONE = 2'd3;

	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic [63:0] DEF_ROM_CODE = 64'd0;
	localparam logic [7:0] DEF_CONVERT_A = 8'h44;
	localparam logic [7:0] DEF_CONVERT_B = 8'h3C;
	localparam logic [7:0] DEF_READ_SCRATCH = 8'hBE;
	localparam logic [7:0] DEF_READ_MEMORY = 8'hAA;
	localparam logic [7:0] DEF_RECALL = 8'hB8;
	localparam logic [7:0] DEF_COPY = 8'h48;
	localparam logic [7:0] DEF_WRITE_SCRATCH = 8'h4E;

	typedef enum logic [1:0] {
		OP_RESET = 2'd0,
		OP_SLOT  = 2'd1,
		OP_LOCAL = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REQ_NONE    = 3'd0,
		REQ_CONVERT = 3'd1,
		REQ_RECALL  = 3'd2,
		REQ_COMMIT  = 3'd3,
		REQ_WRITTEN = 3'd4
	} req_t;

	typedef enum logic [8:0] {
		PH_WAIT    = 9'b000000001,
		PH_ROMCMD  = 9'b000000010,
		PH_ROMBITS = 9'b000000100,
		PH_FUNCCMD = 9'b000001000,
		PH_OFFSET  = 9'b000010000,
		PH_DUMMY   = 9'b000100000,
		PH_SEND    = 9'b001000000,
		PH_SENDCRC = 9'b010000000,
		PH_WRITE   = 9'b100000000
	} phase_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROM_CODE      = 4'd0,
		CFG_CONVERT_A     = 4'd1,
		CFG_CONVERT_B     = 4'd2,
		CFG_READ_SCRATCH  = 4'd3,
		CFG_READ_MEMORY   = 4'd4,
		CFG_RECALL        = 4'd5,
		CFG_COPY          = 4'd6,
		CFG_WRITE_SCRATCH = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] pad;
		logic [7:0] local_value;
		logic [3:0] local_index;
		logic       alarm_active;
		logic       bus_bit;
	} in_data_t;

	typedef struct packed {
		logic [1:0] pad;
		logic       waiting_reset;
		req_t       request;
		logic       presence;
		logic       drive_low;
	} result_t;

endpackage
`default_nettype wire

[sv/onewire_slave_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// 1-Wire slave sequencer working at the level of bus events: each input request is a
// reset pulse (answered with presence), one time slot carrying the sampled master bit, a
// local scratchpad write, or a no-op. ROM commands read, match, skip, search and alarm
// search are handled, then function commands: convert, recall and copy raise a request
// code, write scratchpad stores three bytes at offset 2, read scratchpad and read memory
// send 8 bytes plus the CRC-8 (poly 0x8C reflected). Every input request yields exactly
// one result request. One request is taken per clock unless a stalled output has filled
// both registers; its result passes the input register, then the result register, which
// presents it on the output. A stalled output holds the input back only once both
// registers are full. Configuration writes are taken at any time, one per cycle, and are
// meant to be issued only while no transaction is in flight.
module onewire_slave_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// bus_bit, alarm_active, local_index[3:0], local_value[7:0], zero pad
	input  wire logic [ows_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// operation[1:0]
	input  wire logic [ows_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	// drive_low, presence, request[2:0], waiting_reset, zero pad
	output      logic [ows_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [ows_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [ows_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ows_pkg::*;

	logic [63:0] rom_code_q;
	logic [7:0]  code_convert_a_q, code_convert_b_q, code_read_scratch_q, code_read_memory_q;
	logic [7:0]  code_recall_q, code_copy_q, code_write_scratch_q;

	logic      valid_s1;
	op_t       op_s1;
	in_data_t  data_s1;
	logic      valid_s2;
	result_t   result_s2;
	logic      advance;
	logic      fire_s1;

	phase_t                 phase_q, phase_d;
	logic [6:0]             bit_count_q, bit_count_d;
	logic [1:0]             sub_slot_q, sub_slot_d;
	logic [7:0]             shift_q, shift_d;
	logic [2:0]             rom_mode_q, rom_mode_d;
	logic [7:0]             crc_q, crc_d;
	logic [SCRATCH_AW-1:0]  byte_pointer_q, byte_pointer_d;
	logic [3:0]             bytes_left_q, bytes_left_d;
	logic [7:0]             scratch_q [SCRATCH_BYTES];

	logic                   sp_we;
	logic [SCRATCH_AW-1:0]  sp_waddr;
	logic [7:0]             sp_wdata;

	result_t                result_d;
	logic [7:0]             shift_in;
	logic [6:0]             bc_inc;
	logic                   byte_done;
	logic [2:0]             mode_cmd;
	logic                   rom_bit;
	logic [1:0]             sub_next;
	logic [1:0]             sub_first;
	logic [7:0]             send_byte;
	logic [7:0]             crc_next;
	logic [3:0]             left_dec;

	function automatic logic [1:0] first_sub(input logic [2:0] mode, input logic [1:0] from);
		logic [1:0] r;
		r = SUB_NONE;
		for (int s = 2; s >= 0; s--) begin
			if ((2'(s) >= from) && mode[s]) begin
				r = 2'(s);
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b);
		logic [7:0] c;
		c = c_in ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_code_q <= DEF_ROM_CODE;
			code_convert_a_q <= DEF_CONVERT_A;
			code_convert_b_q <= DEF_CONVERT_B;
			code_read_scratch_q <= DEF_READ_SCRATCH;
			code_read_memory_q <= DEF_READ_MEMORY;
			code_recall_q <= DEF_RECALL;
			code_copy_q <= DEF_COPY;
			code_write_scratch_q <= DEF_WRITE_SCRATCH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROM_CODE:      rom_code_q <= cfg_data;
				CFG_CONVERT_A:     code_convert_a_q <= cfg_data[7:0];
				CFG_CONVERT_B:     code_convert_b_q <= cfg_data[7:0];
				CFG_READ_SCRATCH:  code_read_scratch_q <= cfg_data[7:0];
				CFG_READ_MEMORY:   code_read_memory_q <= cfg_data[7:0];
				CFG_RECALL:        code_recall_q <= cfg_data[7:0];
				CFG_COPY:          code_copy_q <= cfg_data[7:0];
				CFG_WRITE_SCRATCH: code_write_scratch_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance = !valid_s2 || m_axis_tready;
	assign fire_s1 = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata;
		end
		if (fire_s1) begin
			result_s2 <= result_d;
		end
	end

	// slot datapath
	assign shift_in = {data_s1.bus_bit, shift_q[7:1]};
	assign bc_inc = bit_count_q + 7'd1;
	assign byte_done = (bc_inc >= 7'd8);
	assign rom_bit = rom_code_q[bit_count_q[5:0]];
	assign sub_next = (sub_slot_q != SUB_NONE) ? first_sub(rom_mode_q, sub_slot_q + 2'd1)
		: SUB_NONE;
	assign sub_first = first_sub(rom_mode_q, 2'd0);
	assign send_byte = (bit_count_q == 7'd0) ? scratch_q[byte_pointer_q] : shift_q;
	assign crc_next = crc8_byte(crc_q, send_byte);
	assign left_dec = (bytes_left_q != 4'd0) ? (bytes_left_q - 4'd1) : bytes_left_q;

	always_comb begin
		if (shift_in == ROM_MATCH) begin
			mode_cmd = MODE_MATCH;
		end else if (shift_in == ROM_READ) begin
			mode_cmd = MODE_READ;
		end else if (shift_in == ROM_SEARCH || (shift_in == ROM_ALARM && data_s1.alarm_active))
		begin
			mode_cmd = MODE_SEARCH;
		end else begin
			mode_cmd = MODE_NONE;
		end
	end

	always_comb begin
		phase_d = phase_q;
		bit_count_d = bit_count_q;
		sub_slot_d = sub_slot_q;
		shift_d = shift_q;
		rom_mode_d = rom_mode_q;
		crc_d = crc_q;
		byte_pointer_d = byte_pointer_q;
		bytes_left_d = bytes_left_q;
		sp_we = 1'b0;
		sp_waddr = byte_pointer_q;
		sp_wdata = shift_in;
		result_d = '0;
		case (op_s1)
			OP_RESET: begin
				result_d.presence = 1'b1;
				phase_d = PH_ROMCMD;
				bit_count_d = '0;
				sub_slot_d = '0;
				shift_d = '0;
				rom_mode_d = '0;
				crc_d = '0;
				byte_pointer_d = '0;
				bytes_left_d = '0;
			end
			OP_LOCAL: begin
				sp_we = 1'b1;
				sp_waddr = data_s1.local_index[SCRATCH_AW-1:0];
				sp_wdata = data_s1.local_value;
			end
			OP_SLOT: begin
				case (phase_q)
					PH_WAIT: ;
					PH_ROMCMD: begin
						shift_d = shift_in;
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							rom_mode_d = mode_cmd;
							if (shift_in == ROM_SKIP) begin
								phase_d = PH_FUNCCMD;
								shift_d = '0;
							end else if (mode_cmd != MODE_NONE) begin
								phase_d = PH_ROMBITS;
								sub_slot_d = first_sub(mode_cmd, 2'd0);
							end else begin
								phase_d = PH_WAIT;
							end
						end
					end
					PH_ROMBITS: begin
						if (sub_slot_q == 2'd2 && data_s1.bus_bit != rom_bit) begin
							phase_d = PH_WAIT;
						end else begin
							if (sub_slot_q == 2'd0) begin
								result_d.drive_low = ~rom_bit;
							end else if (sub_slot_q == 2'd1) begin
								result_d.drive_low = rom_bit;
							end
							if (sub_next == SUB_NONE) begin
								bit_count_d = bc_inc;
								sub_slot_d = sub_first;
								if (bc_inc >= 7'(ROM_BITS) || sub_first == SUB_NONE) begin
									phase_d = PH_FUNCCMD;
									bit_count_d = '0;
									shift_d = '0;
								end
							end else begin
								sub_slot_d = sub_next;
							end
						end
					end
					PH_FUNCCMD: begin
						shift_d = shift_in;
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							if (shift_in == code_convert_a_q || shift_in == code_convert_b_q)
							begin
								result_d.request = REQ_CONVERT;
								phase_d = PH_WAIT;
							end else if (shift_in == code_read_scratch_q) begin
								byte_pointer_d = '0;
								phase_d = PH_SEND;
								crc_d = '0;
								bytes_left_d = 4'(SEND_BYTES);
							end else if (shift_in == code_read_memory_q) begin
								phase_d = PH_OFFSET;
								shift_d = '0;
							end else if (shift_in == code_recall_q) begin
								result_d.request = REQ_RECALL;
								phase_d = PH_WAIT;
							end else if (shift_in == code_copy_q) begin
								result_d.request = REQ_COMMIT;
								phase_d = PH_WAIT;
							end else if (shift_in == code_write_scratch_q) begin
								phase_d = PH_WRITE;
								shift_d = '0;
								byte_pointer_d = SCRATCH_AW'(WRITE_START);
								bytes_left_d = 4'(WRITE_BYTES);
							end else begin
								phase_d = PH_WAIT;
							end
						end
					end
					PH_OFFSET: begin
						shift_d = shift_in;
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							byte_pointer_d = shift_in[SCRATCH_AW-1:0];
							phase_d = PH_DUMMY;
							shift_d = '0;
						end
					end
					PH_DUMMY: begin
						shift_d = shift_in;
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							phase_d = PH_SEND;
							crc_d = '0;
							bytes_left_d = 4'(SEND_BYTES);
						end
					end
					PH_SEND: begin
						shift_d = send_byte;
						result_d.drive_low = ~send_byte[bit_count_q[2:0]];
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							crc_d = crc_next;
							byte_pointer_d = byte_pointer_q + SCRATCH_AW'(1);
							bytes_left_d = left_dec;
							if (left_dec == 4'd0) begin
								phase_d = PH_SENDCRC;
								shift_d = crc_next;
							end
						end
					end
					PH_SENDCRC: begin
						result_d.drive_low = ~crc_q[bit_count_q[2:0]];
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							phase_d = PH_WAIT;
						end
					end
					PH_WRITE: begin
						shift_d = shift_in;
						bit_count_d = bc_inc;
						if (byte_done) begin
							bit_count_d = '0;
							sp_we = 1'b1;
							byte_pointer_d = byte_pointer_q + SCRATCH_AW'(1);
							bytes_left_d = left_dec;
							if (left_dec == 4'd0) begin
								result_d.request = REQ_WRITTEN;
								phase_d = PH_WAIT;
							end
						end
					end
					default: phase_d = PH_WAIT;
				endcase
			end
			default: ;
		endcase
		result_d.waiting_reset = (phase_d == PH_WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			bit_count_q <= '0;
			sub_slot_q <= '0;
			shift_q <= '0;
			rom_mode_q <= '0;
			crc_q <= '0;
			byte_pointer_q <= '0;
			bytes_left_q <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			bit_count_q <= bit_count_d;
			sub_slot_q <= sub_slot_d;
			shift_q <= shift_d;
			rom_mode_q <= rom_mode_d;
			crc_q <= crc_d;
			byte_pointer_q <= byte_pointer_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	// scratchpad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCRATCH_BYTES; i++) begin
				scratch_q[i] <= '0;
			end
		end else if (fire_s1 && sp_we) begin
			scratch_q[sp_waddr] <= sp_wdata;
		end
	end

`include "onewire_slave_controller_assert.svh"

	`OWS_ASSERT_NXT(a_result_follows, fire_s1, valid_s2)
	`OWS_ASSERT_IMP(a_presence_alone, valid_s2 && result_s2.presence,
		result_s2.request == REQ_NONE && !result_s2.drive_low && !result_s2.waiting_reset)
	`OWS_ASSERT_IMP(a_request_ends, valid_s2 && result_s2.request != REQ_NONE,
		result_s2.waiting_reset)
	`OWS_ASSERT_IMP(a_rom_bits_sane, phase_q == PH_ROMBITS,
		rom_mode_q != MODE_NONE && sub_slot_q != SUB_NONE && bit_count_q < 7'(ROM_BITS))
	`OWS_ASSERT_IMP(a_byte_count, phase_q != PH_ROMBITS && phase_q != PH_WAIT,
		bit_count_q < 7'd8)

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import ows_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DUMP_SLOTS = (SEND_BYTES + 1) * 8;
	localparam int MAX_REPORTS = 50;
	localparam logic [1:0] SUB_SEND = 2'd0;
	localparam logic [1:0] SUB_INVERT = 2'd1;
	localparam logic [1:0] SUB_COMPARE = 2'd2;

	typedef logic [7:1][7:0] code_set_t;
	localparam code_set_t DEFAULT_CODES = {DEF_WRITE_SCRATCH, DEF_COPY, DEF_RECALL,
		DEF_READ_MEMORY, DEF_READ_SCRATCH, DEF_CONVERT_B, DEF_CONVERT_A};

	logic clk = 1'b0;
	logic arst_n;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [IN_TUSER_W-1:0] s_axis_tuser;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// slave state as predicted
	logic [63:0] rom_id;
	logic [7:0] fn_code [1:7];
	phase_t ph;
	logic [6:0] bitn;
	logic [1:0] sub;
	logic [7:0] sreg;
	logic [2:0] mode;
	logic [7:0] crc;
	logic [SCRATCH_AW-1:0] ptr;
	logic [4:0] left;
	logic [7:0] scratch_mem [SCRATCH_BYTES];

	result_t pending_replies [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int side_pmil = 0;
	int break_pmil = 0;
	int errors = 0;
	int cycles = 0;
	int events_sent = 0;
	int replies_checked = 0;
	int transactions = 0;
	int settings_loaded = 0;
	int requests_raised = 0;

	onewire_slave_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [7:0] crc8_byte(logic [7:0] c, logic [7:0] b);
		c ^= b;
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [1:0] next_sub(logic [2:0] m, int from);
		for (int s = from; s < 3; s++)
			if (m[s])
				return s[1:0];
		return SUB_NONE;
	endfunction

	function automatic logic shift_in(logic b);
		sreg = {b, sreg[7:1]};
		bitn++;
		if (bitn >= 8) begin
			bitn = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void enter_byte(phase_t p);
		ph = p;
		bitn = '0;
		sreg = '0;
	endfunction

	function automatic void start_send();
		ph = PH_SEND;
		bitn = '0;
		crc = '0;
		left = 5'(SEND_BYTES);
	endfunction

	function automatic result_t predict_reply(op_t op, in_data_t d);
		result_t r;
		logic rb;
		logic [1:0] nx;
		r = '0;
		r.request = REQ_NONE;
		case (op)
		OP_RESET: begin
			r.presence = 1'b1;
			enter_byte(PH_ROMCMD);
			sub = SUB_SEND;
			mode = MODE_NONE;
			crc = '0;
			ptr = '0;
			left = '0;
		end
		OP_LOCAL: scratch_mem[d.local_index] = d.local_value;
		OP_SLOT: begin
			case (ph)
			PH_ROMCMD: begin
				if (shift_in(d.bus_bit)) begin
					if (sreg == ROM_MATCH)
						mode = MODE_MATCH;
					else if (sreg == ROM_READ)
						mode = MODE_READ;
					else if (sreg == ROM_SEARCH || (sreg == ROM_ALARM && d.alarm_active))
						mode = MODE_SEARCH;
					else
						mode = MODE_NONE;
					if (sreg == ROM_SKIP) begin
						enter_byte(PH_FUNCCMD);
					end else if (mode != MODE_NONE) begin
						ph = PH_ROMBITS;
						bitn = '0;
						sub = next_sub(mode, SUB_SEND);
					end else begin
						ph = PH_WAIT;
					end
				end
			end
			PH_ROMBITS: begin
				rb = rom_id[bitn[5:0]];
				if (sub == SUB_SEND)
					r.drive_low = ~rb;
				else if (sub == SUB_INVERT)
					r.drive_low = rb;
				if (sub == SUB_COMPARE && d.bus_bit != rb) begin
					ph = PH_WAIT;
				end else begin
					nx = (sub == SUB_NONE) ? SUB_NONE : next_sub(mode, int'(sub) + 1);
					if (nx == SUB_NONE) begin
						bitn++;
						sub = next_sub(mode, SUB_SEND);
						if (bitn >= ROM_BITS || sub == SUB_NONE)
							enter_byte(PH_FUNCCMD);
					end else begin
						sub = nx;
					end
				end
			end
			PH_FUNCCMD: begin
				if (shift_in(d.bus_bit)) begin
					if (sreg == fn_code[CFG_CONVERT_A] || sreg == fn_code[CFG_CONVERT_B]) begin
						r.request = REQ_CONVERT;
						ph = PH_WAIT;
					end else if (sreg == fn_code[CFG_READ_SCRATCH]) begin
						ptr = '0;
						start_send();
					end else if (sreg == fn_code[CFG_READ_MEMORY]) begin
						enter_byte(PH_OFFSET);
					end else if (sreg == fn_code[CFG_RECALL]) begin
						r.request = REQ_RECALL;
						ph = PH_WAIT;
					end else if (sreg == fn_code[CFG_COPY]) begin
						r.request = REQ_COMMIT;
						ph = PH_WAIT;
					end else if (sreg == fn_code[CFG_WRITE_SCRATCH]) begin
						enter_byte(PH_WRITE);
						ptr = SCRATCH_AW'(WRITE_START);
						left = 5'(WRITE_BYTES);
					end else begin
						ph = PH_WAIT;
					end
				end
			end
			PH_OFFSET: begin
				if (shift_in(d.bus_bit)) begin
					ptr = sreg[SCRATCH_AW-1:0];
					enter_byte(PH_DUMMY);
				end
			end
			PH_DUMMY: begin
				if (shift_in(d.bus_bit))
					start_send();
			end
			PH_SEND: begin
				if (bitn == 0)
					sreg = scratch_mem[ptr];
				r.drive_low = ~sreg[bitn[2:0]];
				bitn++;
				if (bitn >= 8) begin
					bitn = '0;
					crc = crc8_byte(crc, sreg);
					ptr++;
					if (left != 0)
						left--;
					if (left == 0) begin
						ph = PH_SENDCRC;
						sreg = crc;
					end
				end
			end
			PH_SENDCRC: begin
				r.drive_low = ~crc[bitn[2:0]];
				bitn++;
				if (bitn >= 8) begin
					bitn = '0;
					ph = PH_WAIT;
				end
			end
			PH_WRITE: begin
				if (shift_in(d.bus_bit)) begin
					scratch_mem[ptr] = sreg;
					ptr++;
					if (left != 0)
						left--;
					if (left == 0) begin
						r.request = REQ_WRITTEN;
						ph = PH_WAIT;
					end
				end
			end
			default: ph = PH_WAIT;
			endcase
		end
		default: ;
		endcase
		r.waiting_reset = (ph == PH_WAIT);
		if (r.request != REQ_NONE)
			requests_raised++;
		return r;
	endfunction

	function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : reply_monitor
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_replies.push_back(predict_reply(op_t'(s_axis_tuser),
					in_data_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_replies.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected reply, expected none, actual %h", $time,
							m_axis_tdata);
				end else begin
					want = pending_replies.pop_front();
					check_field("drive_low", 3'(want.drive_low), 3'(got.drive_low));
					check_field("presence", 3'(want.presence), 3'(got.presence));
					check_field("request", want.request, got.request);
					check_field("waiting_reset", 3'(want.waiting_reset),
						3'(got.waiting_reset));
					replies_checked++;
				end
			end
		end
	end

	task automatic bus_event(op_t op, logic bb, logic alarm, logic [3:0] idx, logic [7:0] val);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, val, idx, alarm, bb};
		do @(posedge clk); while (!s_axis_tready);
		if (op != OP_NONE)
			events_sent++;
	endtask

	task automatic bus_reset();
		bus_event(OP_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)),
			4'($urandom_range(15)), 8'($urandom_range(255)));
	endtask

	task automatic slot(logic bb, logic alarm);
		if ($urandom_range(999) < side_pmil) begin
			if ($urandom_range(3) == 0)
				bus_event(OP_NONE, 1'($urandom_range(1)), 1'($urandom_range(1)),
					4'($urandom_range(15)), 8'($urandom_range(255)));
			else
				bus_event(OP_LOCAL, 1'($urandom_range(1)), 1'($urandom_range(1)),
					4'($urandom_range(15)), 8'($urandom_range(255)));
		end
		if ($urandom_range(999) < break_pmil)
			bus_reset();
		bus_event(OP_SLOT, bb, alarm, 4'($urandom_range(15)), 8'($urandom_range(255)));
	endtask

	task automatic read_slots(int n);
		repeat (n) slot(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic send_byte(logic [7:0] b, logic alarm);
		for (int i = 0; i < 8; i++)
			slot(b[i], (i == 7) ? alarm : logic'($urandom_range(1)));
	endtask

	task automatic address_rom(logic [7:0] cmd, logic alarm, int flip_at);
		send_byte(cmd, alarm);
		if (cmd == ROM_READ) begin
			read_slots(ROM_BITS);
		end else if (cmd == ROM_MATCH) begin
			for (int i = 0; i < ROM_BITS; i++) begin
				slot(rom_id[i] ^ (i == flip_at), 1'($urandom_range(1)));
				if (i == flip_at)
					break;
			end
		end else if (cmd == ROM_SEARCH || (cmd == ROM_ALARM && alarm)) begin
			for (int i = 0; i < ROM_BITS; i++) begin
				read_slots(2);
				slot(rom_id[i] ^ (i == flip_at), 1'($urandom_range(1)));
				if (i == flip_at)
					break;
			end
		end
	endtask

	task automatic function_cmd(logic [7:0] code, logic [7:0] offset);
		send_byte(code, 1'($urandom_range(1)));
		if (code != fn_code[CFG_CONVERT_A] && code != fn_code[CFG_CONVERT_B]) begin
			if (code == fn_code[CFG_READ_SCRATCH]) begin
				read_slots(DUMP_SLOTS);
			end else if (code == fn_code[CFG_READ_MEMORY]) begin
				send_byte(offset, 1'($urandom_range(1)));
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
				read_slots(DUMP_SLOTS);
			end else if (code != fn_code[CFG_RECALL] && code != fn_code[CFG_COPY]
					&& code == fn_code[CFG_WRITE_SCRATCH]) begin
				repeat (WRITE_BYTES)
					send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
			end
		end
		transactions++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(logic [63:0] rom, code_set_t codes);
		settle();
		for (int i = CFG_ROM_CODE; i <= CFG_WRITE_SCRATCH; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			if (i == CFG_ROM_CODE)
				cfg_data <= rom;
			else
				cfg_data <= {32'($urandom), 24'($urandom), codes[i]};
			do @(posedge clk); while (!cfg_ready);
			if (i == CFG_ROM_CODE)
				rom_id = rom;
			else
				fn_code[i] = codes[i];
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic random_transaction();
		int pick;
		logic [7:0] rom_cmd;
		logic [7:0] code;
		logic alarm;
		int flip_at;
		pick = $urandom_range(99);
		if (pick < 50)
			rom_cmd = ROM_SKIP;
		else if (pick < 62)
			rom_cmd = ROM_MATCH;
		else if (pick < 72)
			rom_cmd = ROM_READ;
		else if (pick < 80)
			rom_cmd = ROM_SEARCH;
		else if (pick < 90)
			rom_cmd = ROM_ALARM;
		else
			rom_cmd = 8'($urandom_range(255));
		alarm = ($urandom_range(3) != 0);
		flip_at = ($urandom_range(9) == 0) ? int'($urandom_range(63)) : ROM_BITS;
		if ($urandom_range(99) < 88)
			code = fn_code[$urandom_range(7, 1)];
		else
			code = 8'($urandom_range(255));
		bus_reset();
		address_rom(rom_cmd, alarm, flip_at);
		function_cmd(code, 8'($urandom_range(255)));
		read_slots($urandom_range(2));
	endtask

	task automatic test_field_extremes();
		bus_event(OP_SLOT, 1'b1, 1'b1, 4'hF, 8'hFF);
		bus_event(OP_LOCAL, 1'b1, 1'b1, 4'hF, 8'hFF);
		bus_event(OP_LOCAL, 1'b0, 1'b0, 4'h0, 8'h00);
		bus_event(OP_NONE, 1'b1, 1'b1, 4'hF, 8'hFF);
		bus_event(OP_NONE, 1'b0, 1'b0, 4'h0, 8'h00);
		bus_event(OP_RESET, 1'b1, 1'b1, 4'hF, 8'hFF);
		bus_event(OP_SLOT, 1'b0, 1'b0, 4'h0, 8'h00);
		bus_event(OP_SLOT, 1'b0, 1'b1, 4'hA, 8'h5A);
		bus_event(OP_RESET, 1'b0, 1'b0, 4'h0, 8'h00);
		send_byte(8'h00, 1'b0);
		slot(1'b1, 1'b1);
	endtask

	task automatic test_function_commands();
		logic [0:7][7:0] order;
		order = {DEF_WRITE_SCRATCH, DEF_READ_SCRATCH, DEF_READ_MEMORY, DEF_CONVERT_A,
			DEF_CONVERT_B, DEF_RECALL, DEF_COPY, 8'h00};
		for (int i = 0; i < 8; i++) begin
			bus_reset();
			send_byte(ROM_SKIP, 1'b0);
			function_cmd(order[i], 8'hFF);
		end
	endtask

	task automatic test_byte_latch();
		bus_reset();
		send_byte(ROM_SKIP, 1'b0);
		send_byte(DEF_READ_SCRATCH, 1'b0);
		slot(1'b1, 1'b0);
		bus_event(OP_LOCAL, 1'b0, 1'b0, 4'd0, 8'hC3);
		bus_event(OP_LOCAL, 1'b1, 1'b1, 4'd1, 8'h96);
		read_slots(DUMP_SLOTS - 1);
	endtask

	task automatic test_rom_commands();
		load_settings(64'h5A3C_0F96_E1D2_7B28, DEFAULT_CODES);
		bus_reset();
		address_rom(ROM_READ, 1'b0, ROM_BITS);
		function_cmd(DEF_CONVERT_A, 8'h00);
		bus_reset();
		address_rom(ROM_MATCH, 1'b0, ROM_BITS);
		function_cmd(DEF_RECALL, 8'h00);
		bus_reset();
		address_rom(ROM_MATCH, 1'b0, ROM_BITS - 1);
		slot(1'b1, 1'b0);
		bus_reset();
		address_rom(ROM_SEARCH, 1'b0, ROM_BITS);
		function_cmd(DEF_COPY, 8'h00);
		bus_reset();
		address_rom(ROM_SEARCH, 1'b0, 2);
		slot(1'b0, 1'b0);
		bus_reset();
		address_rom(ROM_ALARM, 1'b0, ROM_BITS);
		slot(1'b1, 1'b1);
		bus_reset();
		address_rom(ROM_ALARM, 1'b1, 5);
		slot(1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(int round);
		code_set_t codes;
		logic [63:0] rom;
		int stop_at;
		for (int i = 1; i <= 7; i++)
			codes[i] = 8'($urandom_range(255));
		rom = {$urandom, $urandom};
		case (round)
		0: begin
			rom = '1;
			codes = DEFAULT_CODES;
			codes[CFG_CONVERT_A] = 8'h00;
			codes[CFG_CONVERT_B] = 8'hFF;
		end
		2: begin
			rom = '0;
			codes = DEFAULT_CODES;
			codes[CFG_COPY] = DEF_RECALL;
		end
		default: ;
		endcase
		load_settings(rom, codes);
		case (round)
		0: begin send_idle_pct = 0; recv_stall_pct = 0; end
		1: begin send_idle_pct = 77; recv_stall_pct = 0; end
		2: begin send_idle_pct = 0; recv_stall_pct = 77; end
		default: begin send_idle_pct = 12; recv_stall_pct = 12; end
		endcase
		side_pmil = 60;
		break_pmil = 3;
		stop_at = events_sent + 40;
		while (events_sent < stop_at)
			random_transaction();
	endtask

	initial begin
		rom_id = '0;
		for (int i = 1; i <= 7; i++)
			fn_code[i] = DEFAULT_CODES[i];
		ph = PH_WAIT;
		bitn = '0;
		sub = SUB_SEND;
		sreg = '0;
		mode = MODE_NONE;
		crc = '0;
		ptr = '0;
		left = '0;
		for (int i = 0; i < SCRATCH_BYTES; i++)
			scratch_mem[i] = '0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= OP_NONE;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ROM_CODE;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_function_commands();
		test_byte_latch();
		test_rom_commands();
		for (int r = 0; r < 4; r++)
			test_random_traffic(r);
		settle();
		$display("drove %0d bus events in %0d transactions across %0d register settings",
			events_sent, transactions, settings_loaded);
		$display("compared %0d replies, %0d requests raised, %0d mismatches",
			replies_checked, requests_raised, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
